// ----- rtl/lpmr_pkg.sv -----
// Shared types and constants of the length-prefixed message ring.
`timescale 1ns / 1ps
package lpmr_pkg;

  // Request modes.
  localparam logic [2:0] MODE_SEND_START = 3'd0;
  localparam logic [2:0] MODE_SEND_BYTE  = 3'd1;
  localparam logic [2:0] MODE_GET        = 3'd2;
  localparam logic [2:0] MODE_PEEK       = 3'd3;
  localparam logic [2:0] MODE_READ_BYTE  = 3'd4;
  localparam logic [2:0] MODE_DELETE     = 3'd5;

  // Result status codes.
  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_MISUSE  = 3'd1;
  localparam logic [2:0] STAT_NOSPACE = 3'd2;
  localparam logic [2:0] STAT_NOMSG   = 3'd3;
  localparam logic [2:0] STAT_CORRUPT = 3'd4;

  // Bytes in a message header.
  localparam int HDR_BYTES = 4;

  typedef struct packed {
    logic [2:0]  mode;
    logic [11:0] msg_length;
    logic [7:0]  data_byte;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  read_byte;
    logic [11:0] head_length;
    logic        last;
    logic [11:0] fill_level;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       hdr_wr;
    logic       wr_byte;
    logic       hdr_rd;
    logic       hdr_shift;
    logic       rd_issue;
    logic       rd_pop;
    logic       flush;
    logic       head_skip;
    logic       rd_open;
    logic       respond;
    logic [2:0] status;
    logic       with_hlen;
    logic       with_byte;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] mode;
    logic       wr_open;
    logic       rd_open;
    logic       len_zero;
    logic       space_ok;
    logic       fill_zero;
    logic       fill_small;
    logic       hdr_bad;
    logic       hdr_zero;
    logic       idx_zero;
    logic       idx_last;
  } stat_t;

endpackage

// ----- rtl/lpmr_ctrl.sv -----
// Controller state machine of the message ring.
`timescale 1ns / 1ps
module lpmr_ctrl
  import lpmr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output logic  busy,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_HDR_WR,
    S_HDR_RD,
    S_HDR_LAST,
    S_HDR_CHK,
    S_RD_WAIT,
    S_RESP
  } state_t;

  state_t     state, state_next;
  logic [2:0] code, code_next;
  logic       hlen_flag, hlen_flag_next;
  logic       byte_flag, byte_flag_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    code_next      = code;
    hlen_flag_next = hlen_flag;
    byte_flag_next = byte_flag;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        hlen_flag_next = 1'b0;
        byte_flag_next = 1'b0;
        state_next     = S_RESP;
        code_next      = STAT_MISUSE;
        unique case (stat.mode) inside
          MODE_SEND_START: begin
            if (stat.wr_open || stat.len_zero) begin
              code_next = STAT_MISUSE;
            end else if (!stat.space_ok) begin
              code_next = STAT_NOSPACE;
            end else begin
              state_next = S_HDR_WR;
            end
          end
          MODE_SEND_BYTE: begin
            if (stat.wr_open) begin
              cmd.wr_byte = 1'b1;
              code_next   = STAT_OK;
            end
          end
          MODE_GET, MODE_PEEK, MODE_DELETE: begin
            if (stat.rd_open) begin
              code_next = STAT_MISUSE;
            end else if (stat.fill_zero) begin
              code_next = STAT_NOMSG;
            end else if (stat.fill_small) begin
              code_next = STAT_CORRUPT;
              cmd.flush = (stat.mode != MODE_PEEK);
            end else begin
              state_next = S_HDR_RD;
            end
          end
          MODE_READ_BYTE: begin
            if (stat.rd_open) begin
              cmd.rd_issue = 1'b1;
              state_next   = S_RD_WAIT;
            end
          end
          default: begin
            code_next = STAT_MISUSE;
          end
        endcase
      end
      S_HDR_WR: begin
        cmd.hdr_wr = 1'b1;
        if (stat.idx_last) begin
          code_next  = STAT_OK;
          state_next = S_RESP;
        end
      end
      S_HDR_RD: begin
        cmd.hdr_rd    = 1'b1;
        cmd.hdr_shift = !stat.idx_zero;
        if (stat.idx_last) begin
          state_next = S_HDR_LAST;
        end
      end
      S_HDR_LAST: begin
        cmd.hdr_shift = 1'b1;
        state_next    = S_HDR_CHK;
      end
      S_HDR_CHK: begin
        state_next = S_RESP;
        if (stat.hdr_bad) begin
          code_next = STAT_CORRUPT;
          cmd.flush = (stat.mode != MODE_PEEK);
        end else begin
          code_next      = STAT_OK;
          hlen_flag_next = 1'b1;
          if ((stat.mode == MODE_DELETE) || ((stat.mode == MODE_GET) && stat.hdr_zero)) begin
            cmd.head_skip = 1'b1;
          end else if (!stat.hdr_zero) begin
            cmd.rd_open = 1'b1;
          end
        end
      end
      S_RD_WAIT: begin
        cmd.rd_pop     = 1'b1;
        code_next      = STAT_OK;
        byte_flag_next = 1'b1;
        state_next     = S_RESP;
      end
      S_RESP: begin
        cmd.respond   = 1'b1;
        cmd.status    = code;
        cmd.with_hlen = hlen_flag;
        cmd.with_byte = byte_flag;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      code      <= STAT_OK;
      hlen_flag <= 1'b0;
      byte_flag <= 1'b0;
    end else begin
      state     <= state_next;
      code      <= code_next;
      hlen_flag <= hlen_flag_next;
      byte_flag <= byte_flag_next;
    end
  end

endmodule

// ----- rtl/lpmr_datapath.sv -----
// Datapath of the message ring: byte memory, pointers, header register, result.
`timescale 1ns / 1ps
module lpmr_datapath
  import lpmr_pkg::*;
#(
  parameter int RING_BYTES  = 4096,
  parameter int SPARE_BYTES = 8
) (
  input  logic  clk,
  input  logic  rst,
  input  req_t  request,
  input  cmd_t  cmd,
  output stat_t stat,
  output logic  done,
  output rsp_t  result
);

  localparam int PW = $clog2(RING_BYTES);
  localparam int SW = ((PW > 12) ? PW : 12) + 2;
  localparam logic [PW-1:0] HDR_STEP = PW'(HDR_BYTES);
  localparam logic [PW-1:0] ONE      = PW'(1);

  logic [PW-1:0] head_ptr, tail_ptr, wr_cur, rd_cur;
  logic [11:0]   wr_rem, rd_rem;
  logic          rd_commit;
  logic [1:0]    idx;

  req_t          req_q;
  logic [31:0]   hdr;
  logic          last_q;
  logic [7:0]    mem_rdata;
  logic [7:0]    ring_mem [RING_BYTES];

  logic [PW-1:0] fill;
  logic [31:0]   fill32;
  logic [31:0]   msg32;
  logic [PW-1:0] idx_ext;
  logic [SW-1:0] need;
  logic [PW-1:0] mem_addr;
  logic          mem_we, mem_re;
  logic [7:0]    mem_wdata;

  assign fill    = tail_ptr - head_ptr;
  assign fill32  = 32'(fill);
  assign msg32   = 32'(req_q.msg_length);
  assign idx_ext = PW'(idx);
  assign need    = SW'(req_q.msg_length) + SW'(HDR_BYTES) + SW'(SPARE_BYTES) + SW'(fill);

  always_comb begin
    stat.mode       = req_q.mode;
    stat.wr_open    = (wr_rem != 12'd0);
    stat.rd_open    = (rd_rem != 12'd0);
    stat.len_zero   = (req_q.msg_length == 12'd0);
    stat.space_ok   = (need <= SW'(RING_BYTES));
    stat.fill_zero  = (fill == '0);
    stat.fill_small = (fill32 <= 32'(HDR_BYTES));
    stat.hdr_bad    = (hdr > (fill32 - 32'(HDR_BYTES)));
    stat.hdr_zero   = (hdr == 32'd0);
    stat.idx_zero   = (idx == 2'd0);
    stat.idx_last   = (idx == 2'd3);
  end

  // One memory port, chosen by the active command.
  always_comb begin
    mem_we    = cmd.hdr_wr | cmd.wr_byte;
    mem_re    = cmd.hdr_rd | cmd.rd_issue;
    mem_wdata = cmd.hdr_wr ? msg32[8*idx +: 8] : req_q.data_byte;
    if (cmd.hdr_wr) begin
      mem_addr = tail_ptr + idx_ext;
    end else if (cmd.wr_byte) begin
      mem_addr = wr_cur;
    end else if (cmd.hdr_rd) begin
      mem_addr = head_ptr + idx_ext;
    end else begin
      mem_addr = rd_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= ring_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr  <= '0;
      tail_ptr  <= '0;
      wr_cur    <= '0;
      wr_rem    <= '0;
      rd_cur    <= '0;
      rd_rem    <= '0;
      rd_commit <= 1'b0;
      idx       <= '0;
      done      <= 1'b0;
    end else begin
      done <= cmd.respond;
      if (cmd.capture) begin
        idx <= '0;
      end else if (cmd.hdr_wr || cmd.hdr_rd) begin
        idx <= idx + 2'd1;
      end
      if (cmd.hdr_wr && (idx == 2'd3)) begin
        wr_cur <= tail_ptr + HDR_STEP;
        wr_rem <= req_q.msg_length;
      end
      if (cmd.wr_byte) begin
        wr_cur <= wr_cur + ONE;
        wr_rem <= wr_rem - 12'd1;
        if (wr_rem == 12'd1) begin
          tail_ptr <= wr_cur + ONE;
        end
      end
      if (cmd.rd_pop) begin
        rd_cur <= rd_cur + ONE;
        rd_rem <= rd_rem - 12'd1;
        if ((rd_rem == 12'd1) && rd_commit) begin
          head_ptr <= rd_cur + ONE;
        end
      end
      if (cmd.flush) begin
        head_ptr <= tail_ptr;
      end
      if (cmd.head_skip) begin
        head_ptr <= head_ptr + HDR_STEP + hdr[PW-1:0];
      end
      if (cmd.rd_open) begin
        rd_cur    <= head_ptr + HDR_STEP;
        rd_rem    <= hdr[11:0];
        rd_commit <= (req_q.mode == MODE_GET);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q  <= request;
      last_q <= 1'b0;
    end
    if (cmd.rd_pop) begin
      last_q <= (rd_rem == 12'd1);
    end
    if (cmd.hdr_shift) begin
      hdr <= {mem_rdata, hdr[31:8]};
    end
    if (cmd.respond) begin
      result.status      <= cmd.status;
      result.read_byte   <= cmd.with_byte ? mem_rdata : 8'd0;
      result.head_length <= cmd.with_hlen ? hdr[11:0] : 12'd0;
      result.last        <= last_q;
      result.fill_level  <= fill32[11:0];
    end
  end

endmodule

// ----- rtl/length_prefixed_message_ring_unit.sv -----
// Top level of the length-prefixed message ring: controller plus datapath.
// Each request passes dispatch and response, which registers the result;
// a read byte adds a memory wait, a send start the header writes, and get, peek
// or delete the header reads, last shift and check. One request is served at a
// time; headers take four accesses each on the single byte-wide memory port.
// The receiver cannot stall results. Reset is synchronous and active high; it
// clears all pointers and runs no clearing pass, so it takes requests at once.
`timescale 1ns / 1ps
module length_prefixed_message_ring_unit
  import lpmr_pkg::*;
#(
  parameter int RING_BYTES  = 4096,
  parameter int SPARE_BYTES = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic done,
  output rsp_t result
);

  // The controller sequences each request through the datapath. It samples
  // start only while idle and drives one command word per cycle; the datapath
  // answers with a status word built from its pointers and header register.
  cmd_t  cmd;
  stat_t stat;

  lpmr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // The datapath owns the byte memory, the head and tail pointers, the open
  // send and read cursors, and the registered result with its strobe.
  lpmr_datapath #(
    .RING_BYTES  (RING_BYTES),
    .SPARE_BYTES (SPARE_BYTES)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .done    (done),
    .result  (result)
  );

endmodule

// ----- rtl/lpmr_checker.sv -----
// Port-level assertions for the message ring, bound to the top level.
`timescale 1ns / 1ps
module lpmr_checker
  import lpmr_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t result
);

  // A request that is taken makes the unit busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // The unit only becomes busy by taking a request.
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

  // A result is shown only once its request is finished.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // The end-of-message flag comes only with a successful byte read.
  a_last_ok: assert property (@(posedge clk) disable iff (rst)
    (done && result.last) |-> (result.status == STAT_OK))
    else $error("last flag on a failed request");

endmodule

bind length_prefixed_message_ring_unit lpmr_checker u_lpmr_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

// ----- bench/length_prefixed_message_ring_unit_tb.sv -----
// Self-checking testbench for the length-prefixed message ring unit.
`timescale 1ns / 1ps
module length_prefixed_message_ring_unit_tb;
  import lpmr_pkg::*;

  // The unit is built with its default geometry; the ring model below mirrors it.
  localparam int RING_BYTES  = 4096;
  localparam int SPARE_BYTES = 8;

  // Modes 6 and 7 have no meaning in the unit and must be refused as misuse.
  localparam logic [2:0] MODE_UNUSED_A = 3'd6;
  localparam logic [2:0] MODE_UNUSED_B = 3'd7;

  // The slowest correct run ends well before this cycle limit.
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t request = '0;
  logic busy;
  logic done;
  rsp_t result;

  int cycle_count = 0;
  int errors = 0;

  // Results that accepted requests still owe, oldest first.
  rsp_t expected_rsps[$];

  // Software copy of the ring: byte store, committed pointers and the
  // progress of the send and the read that may be open.
  bit [7:0]  ring_mem [RING_BYTES];
  bit [11:0] head_idx;
  bit [11:0] tail_idx;
  bit [11:0] wr_pos;
  bit [11:0] wr_left;
  bit [11:0] rd_pos;
  bit [11:0] rd_left;
  bit        rd_commit;

  // A directed request with, where it is obvious, the result typed in by hand.
  typedef struct {
    req_t req;
    bit   known;
    rsp_t want;
  } plan_row_t;

  plan_row_t directed_plan[$];

  length_prefixed_message_ring_unit #(
    .RING_BYTES (RING_BYTES),
    .SPARE_BYTES(SPARE_BYTES)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .done   (done),
    .result (result)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_rsps.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    errors++;
    // Keep the log bounded when something breaks badly.
    if (errors <= 100) $display("cycle %0d: %s", cycle_count, msg);
  endtask

  // Bytes between the committed head and tail; 12-bit wrap matches the ring size.
  function automatic bit [11:0] ring_fill();
    return tail_idx - head_idx;
  endfunction

  // Applies one request to the ring copy and returns the result it must produce.
  function automatic rsp_t ring_predict(input req_t r);
    rsp_t o;
    int space;
    bit [11:0] fill;
    bit [31:0] hdr;
    logic [2:0] chk;
    o = '0;
    o.status = STAT_OK;
    case (r.mode)
      MODE_SEND_START: begin
        space = RING_BYTES - int'(ring_fill()) - SPARE_BYTES;
        if (wr_left != 0 || r.msg_length == 0) begin
          o.status = STAT_MISUSE;
        end else if (space <= 0 || int'(r.msg_length) + HDR_BYTES > space) begin
          o.status = STAT_NOSPACE;
        end else begin
          // The header goes in little-endian now; tail moves only when the
          // last payload byte has been written.
          for (int i = 0; i < HDR_BYTES; i++)
            ring_mem[12'(tail_idx + i)] = 8'(32'(r.msg_length) >> (8 * i));
          wr_pos = 12'(tail_idx + HDR_BYTES);
          wr_left = r.msg_length;
        end
      end
      MODE_SEND_BYTE: begin
        if (wr_left == 0) begin
          o.status = STAT_MISUSE;
        end else begin
          ring_mem[wr_pos] = r.data_byte;
          wr_pos++;
          wr_left--;
          if (wr_left == 0) tail_idx = wr_pos;
        end
      end
      MODE_GET, MODE_PEEK, MODE_DELETE: begin
        if (rd_left != 0) begin
          o.status = STAT_MISUSE;
        end else begin
          fill = ring_fill();
          hdr = '0;
          if (fill == 0) begin
            chk = STAT_NOMSG;
          end else if (fill <= HDR_BYTES) begin
            chk = STAT_CORRUPT;
          end else begin
            for (int i = 0; i < HDR_BYTES; i++)
              hdr |= 32'(ring_mem[12'(head_idx + i)]) << (8 * i);
            chk = (hdr > 32'(fill) - HDR_BYTES) ? STAT_CORRUPT : STAT_OK;
          end
          o.status = chk;
          if (chk == STAT_CORRUPT && r.mode != MODE_PEEK) begin
            // A bad header cannot be skipped safely, so get and delete drop everything.
            head_idx = tail_idx;
          end else if (chk == STAT_OK) begin
            o.head_length = hdr[11:0];
            if (r.mode == MODE_DELETE || (r.mode == MODE_GET && hdr == 0)) begin
              head_idx = 12'(head_idx + HDR_BYTES + hdr);
            end else if (hdr != 0) begin
              rd_pos = 12'(head_idx + HDR_BYTES);
              rd_left = hdr[11:0];
              rd_commit = (r.mode == MODE_GET);
            end
          end
        end
      end
      MODE_READ_BYTE: begin
        if (rd_left == 0) begin
          o.status = STAT_MISUSE;
        end else begin
          o.read_byte = ring_mem[rd_pos];
          rd_pos++;
          rd_left--;
          if (rd_left == 0) begin
            o.last = 1'b1;
            // Only a get releases the message; a peek leaves it at the head.
            if (rd_commit) head_idx = rd_pos;
          end
        end
      end
      default: o.status = STAT_MISUSE;
    endcase
    o.fill_level = ring_fill();
    return o;
  endfunction

  function automatic req_t make_req(input logic [2:0] mode, input int len, input int data);
    req_t r;
    r.mode = mode;
    r.msg_length = 12'(len);
    r.data_byte = 8'(data);
    return r;
  endfunction

  function automatic void plan_known(input logic [2:0] mode, input int len, input int data,
                                     input logic [2:0] status, input int rbyte,
                                     input int hlen, input bit last, input int fill);
    plan_row_t row;
    row.req = make_req(mode, len, data);
    row.known = 1'b1;
    row.want = '{status: status, read_byte: 8'(rbyte), head_length: 12'(hlen),
                 last: last, fill_level: 12'(fill)};
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_checked(input logic [2:0] mode, input int len, input int data);
    plan_row_t row;
    row.req = make_req(mode, len, data);
    row.known = 1'b0;
    row.want = '0;
    directed_plan.push_back(row);
  endfunction

  // Presents one request after an idle gap and holds it until the unit takes
  // it. Every call begins and ends on a rising edge. start is only lowered
  // when a gap follows, so a back-to-back request never sees start drop.
  // busy is sampled at the falling edge, where it is stable for the next
  // rising edge, so acceptance does not depend on event order at the edge.
  task automatic ring_request(input req_t r, input int gap, input bit known,
                              input rsp_t want);
    bit free_now;
    rsp_t guess;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= r;
    do begin
      @(negedge clk);
      free_now = !busy;
      @(posedge clk);
    end while (!free_now);
    // The ring copy advances on every accepted request, even where the
    // expected result was typed in by hand.
    guess = ring_predict(r);
    expected_rsps.push_back(known ? want : guess);
  endtask

  // Stop sending and wait until every accepted request has been answered.
  task automatic wait_drain();
    start <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
  endtask

  // Random traffic that mostly follows well-formed send and read sequences
  // with random content, mixed with broken sequences and pure noise. The
  // choice of the next request looks at the ring copy, so open sends and
  // reads are usually carried on, but not always.
  task automatic random_traffic(input int count);
    req_t r;
    int pick;
    int sub;
    int gap;
    bit steady;
    steady = 1'b0;
    for (int n = 0; n < count; n++) begin
      // Every so often the sender runs flat out for a stretch.
      if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      gap = steady ? 0 : $urandom_range(0, 15);
      pick = $urandom_range(0, 99);
      r = make_req(MODE_SEND_BYTE, 0, $urandom_range(0, 255));
      if (pick < 8) begin
        r.mode = 3'($urandom_range(0, 7));
        r.msg_length = 12'($urandom_range(0, 4095));
        // A random length could open a send thousands of bytes long; keep
        // large noise lengths in the no-space region instead.
        if (r.mode == MODE_SEND_START && wr_left == 0 && r.msg_length > 64)
          r.msg_length = 12'(4085 + $urandom_range(0, 10));
      end else if (wr_left != 0 && pick < 55) begin
        r.mode = MODE_SEND_BYTE;
      end else if (rd_left != 0 && pick < 85) begin
        r.mode = MODE_READ_BYTE;
      end else begin
        sub = $urandom_range(0, 9);
        if (sub < 4) begin
          r.mode = MODE_SEND_START;
          r.msg_length = ($urandom_range(0, 19) == 0) ? 12'($urandom_range(1, 300)) :
                                                        12'($urandom_range(1, 16));
        end else if (sub < 7) begin
          r.mode = MODE_GET;
        end else if (sub < 8) begin
          r.mode = MODE_PEEK;
        end else begin
          r.mode = MODE_DELETE;
        end
      end
      ring_request(r, gap, 1'b0, '0);
      // Halfway through, the sender waits for the unit to go quiet once.
      if (n == count / 2) wait_drain();
    end
  endtask

  // Results are sampled at the falling edge, after the unit drives them at the
  // rising edge, and each one is matched against the oldest expectation.
  always @(negedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (expected_rsps.size() == 0) begin
        report_mismatch($sformatf("result with no request waiting: status %0d fill %0d",
                                  result.status, result.fill_level));
      end else begin
        want = expected_rsps.pop_front();
        if (result.status !== want.status)
          report_mismatch($sformatf("status got %0d, expected %0d",
                                    result.status, want.status));
        if (result.read_byte !== want.read_byte)
          report_mismatch($sformatf("read_byte got %0h, expected %0h",
                                    result.read_byte, want.read_byte));
        if (result.head_length !== want.head_length)
          report_mismatch($sformatf("head_length got %0d, expected %0d",
                                    result.head_length, want.head_length));
        if (result.last !== want.last)
          report_mismatch($sformatf("last got %0b, expected %0b", result.last, want.last));
        if (result.fill_level !== want.fill_level)
          report_mismatch($sformatf("fill_level got %0d, expected %0d",
                                    result.fill_level, want.fill_level));
      end
    end
  end

  initial begin
    // Empty ring: nothing to get, peek or delete, and nothing open to continue.
    plan_known(MODE_GET,        0,    0,     STAT_NOMSG,   0,     0, 1'b0, 0);
    plan_known(MODE_PEEK,       0,    0,     STAT_NOMSG,   0,     0, 1'b0, 0);
    plan_known(MODE_DELETE,     0,    0,     STAT_NOMSG,   0,     0, 1'b0, 0);
    plan_known(MODE_READ_BYTE,  0,    0,     STAT_MISUSE,  0,     0, 1'b0, 0);
    plan_known(MODE_SEND_BYTE,  0,    8'hFF, STAT_MISUSE,  0,     0, 1'b0, 0);
    plan_known(MODE_UNUSED_A,   4095, 8'hFF, STAT_MISUSE,  0,     0, 1'b0, 0);
    plan_known(MODE_UNUSED_B,   0,    0,     STAT_MISUSE,  0,     0, 1'b0, 0);
    // Zero length is misuse; the largest lengths exceed the space of an empty ring.
    plan_known(MODE_SEND_START, 0,    0,     STAT_MISUSE,  0,     0, 1'b0, 0);
    plan_known(MODE_SEND_START, 4095, 0,     STAT_NOSPACE, 0,     0, 1'b0, 0);
    plan_known(MODE_SEND_START, 4085, 0,     STAT_NOSPACE, 0,     0, 1'b0, 0);
    // A three-byte message only becomes visible after its last byte.
    plan_known(MODE_SEND_START, 3,    8'hFF, STAT_OK,      0,     0, 1'b0, 0);
    plan_known(MODE_SEND_START, 5,    0,     STAT_MISUSE,  0,     0, 1'b0, 0);
    plan_known(MODE_SEND_BYTE,  0,    8'h00, STAT_OK,      0,     0, 1'b0, 0);
    plan_known(MODE_SEND_BYTE,  0,    8'hFF, STAT_OK,      0,     0, 1'b0, 0);
    plan_known(MODE_SEND_BYTE,  0,    8'h5A, STAT_OK,      0,     0, 1'b0, 7);
    // Peek streams the payload but leaves the message in place.
    plan_known(MODE_PEEK,       0,    0,     STAT_OK,      0,     3, 1'b0, 7);
    plan_known(MODE_READ_BYTE,  0,    0,     STAT_OK,      8'h00, 0, 1'b0, 7);
    plan_known(MODE_DELETE,     0,    0,     STAT_MISUSE,  0,     0, 1'b0, 7);
    plan_known(MODE_READ_BYTE,  0,    0,     STAT_OK,      8'hFF, 0, 1'b0, 7);
    plan_known(MODE_READ_BYTE,  0,    0,     STAT_OK,      8'h5A, 0, 1'b1, 7);
    // With seven bytes held, a length one byte beyond the free space is refused.
    plan_known(MODE_SEND_START, 4078, 0,     STAT_NOSPACE, 0,     0, 1'b0, 7);
    // Get with a send interleaved in the middle of the read, then a delete.
    plan_checked(MODE_GET,        0, 0);
    plan_checked(MODE_READ_BYTE,  0, 0);
    plan_checked(MODE_SEND_START, 1, 0);
    plan_checked(MODE_SEND_BYTE,  0, 8'hA5);
    plan_checked(MODE_READ_BYTE,  0, 0);
    plan_checked(MODE_READ_BYTE,  0, 0);
    plan_checked(MODE_DELETE,     0, 0);

    // Reset is held and then released; the unit takes requests right after it.
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i])
      ring_request(directed_plan[i].req, $urandom_range(0, 15), directed_plan[i].known,
                   directed_plan[i].want);
    wait_drain();

    random_traffic(650);
    wait_drain();

    // A late or extra result would show up within the unit's longest latency.
    repeat (12) @(posedge clk);
    if (expected_rsps.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_rsps.size()));

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
